// ===== rtl/core/jnlr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jnlr_pkg: shared types and constants for the non-finite literal rewriter
// Pattern and replacement text, window sizing, and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package jnlr_pkg;

  localparam int WIN_DEPTH = 10;
  localparam int FILL_W    = 4;
  localparam int REP_CNT_W = 5;
  localparam int NUM_PAT   = 4;
  localparam int MAX_PLEN  = 9;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  // Patterns in match priority order
  typedef enum logic [1:0] {
    PAT_NEG_INF,
    PAT_POS_INF,
    PAT_NAN_UP,
    PAT_NAN_LO
  } pat_t;

  localparam logic [8*9-1:0]  PAT_NEG_TXT = "-Infinity";
  localparam logic [8*8-1:0]  PAT_POS_TXT = "Infinity";
  localparam logic [8*3-1:0]  PAT_NUP_TXT = "NaN";
  localparam logic [8*3-1:0]  PAT_NLO_TXT = "nan";

  localparam logic [8*24-1:0] REP_NEG_TXT = "-1.7976931348623157e+308";
  localparam logic [8*23-1:0] REP_POS_TXT = "1.7976931348623157e+308";
  localparam logic [8*4-1:0]  REP_NUL_TXT = "null";

  localparam logic [FILL_W-1:0] PLEN_NEG = 4'd9;
  localparam logic [FILL_W-1:0] PLEN_POS = 4'd8;
  localparam logic [FILL_W-1:0] PLEN_NAN = 4'd3;

  localparam logic [REP_CNT_W-1:0] RLEN_NEG = 5'd24;
  localparam logic [REP_CNT_W-1:0] RLEN_POS = 5'd23;
  localparam logic [REP_CNT_W-1:0] RLEN_NUL = 5'd4;

  // Controller to datapath
  typedef struct packed {
    logic head_go;   // resolve the window head and emit its first byte
    logic rep_go;    // emit the next replacement byte
    logic append;    // write the accepted input beat into the window
    logic at_end;    // flushing: end of text counts as a border
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic fill_zero;
    logic fill_one;
    logic head_rep;  // head starts a replaceable word
    logic rep_final; // current replacement byte is the last one
    logic emit_ok;   // output register can take a byte
  } sts_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic [FILL_W-1:0] pat_len(input pat_t p);
    logic [FILL_W-1:0] len;
    unique case (p)
      PAT_NEG_INF: len = PLEN_NEG;
      PAT_POS_INF: len = PLEN_POS;
      default:     len = PLEN_NAN;
    endcase
    return len;
  endfunction

  function automatic logic [REP_CNT_W-1:0] rep_len(input pat_t p);
    logic [REP_CNT_W-1:0] len;
    unique case (p)
      PAT_NEG_INF: len = RLEN_NEG;
      PAT_POS_INF: len = RLEN_POS;
      default:     len = RLEN_NUL;
    endcase
    return len;
  endfunction

  // Character k of pattern p; zero past the end
  function automatic logic [7:0] pat_char(input pat_t p, input int k);
    logic [7:0] c;
    c = 8'h00;
    unique case (p)
      PAT_NEG_INF: if (k < 9) c = PAT_NEG_TXT[8*(8-k) +: 8];
      PAT_POS_INF: if (k < 8) c = PAT_POS_TXT[8*(7-k) +: 8];
      PAT_NAN_UP:  if (k < 3) c = PAT_NUP_TXT[8*(2-k) +: 8];
      default:     if (k < 3) c = PAT_NLO_TXT[8*(2-k) +: 8];
    endcase
    return c;
  endfunction

  // Character k of the replacement for pattern p; zero past the end
  function automatic logic [7:0] rep_char(input pat_t p, input logic [REP_CNT_W-1:0] k);
    logic [7:0] c;
    int         ki;
    ki = int'(k);
    c  = 8'h00;
    unique case (p)
      PAT_NEG_INF: if (ki < 24) c = REP_NEG_TXT[8*(23-ki) +: 8];
      PAT_POS_INF: if (ki < 23) c = REP_POS_TXT[8*(22-ki) +: 8];
      default:     if (ki < 4)  c = REP_NUL_TXT[8*(3-ki) +: 8];
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/jnlr_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jnlr_in_if: raw JSON byte stream channel
// One text byte per beat with a last-byte flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface jnlr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/core/jnlr_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jnlr_out_if: rewritten JSON byte stream channel
// One output byte per beat with a last-byte flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface jnlr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/core/jnlr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jnlr_datapath: lookahead window, scanner flags and output register
// Holds the ten-byte window, matches the four patterns at its head,
// shifts the window and drives the output beat under controller command.
// ----------------------------------------------------------------------------
module jnlr_datapath import jnlr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       out_ready
);

  logic [7:0]           win_r   [WIN_DEPTH];
  logic [7:0]           win_nxt [WIN_DEPTH];
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic                 instr_r, instr_nxt;
  logic                 esc_r, esc_nxt;
  logic                 prev_r, prev_nxt;
  pat_t                 rep_pat_r, rep_pat_nxt;
  logic [REP_CNT_W-1:0] rep_cnt_r, rep_cnt_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic [7:0]           obyte_r, obyte_nxt;
  logic                 olast_r, olast_nxt;

  logic [NUM_PAT-1:0]   pat_hit;
  logic                 hit;
  pat_t                 hit_pat;
  logic [FILL_W-1:0]    hit_len;
  logic                 head_rep;
  logic                 rep_final;
  logic                 emit_ok;
  logic [FILL_W-1:0]    drop;
  logic [FILL_W-1:0]    fill_mid;
  logic                 emit;
  logic                 text_end;
  logic [7:0]           head;

  assign head      = win_r[0];
  assign emit_ok   = !ovalid_r || out_ready;
  assign rep_final = (rep_cnt_r == rep_len(rep_pat_r) - 5'd1);

  // Pattern match at the window head, each pattern at fixed offsets
  always_comb begin
    logic             eq;
    logic [FILL_W-1:0] len;
    for (int pi = 0; pi < NUM_PAT; pi++) begin
      len = pat_len(pat_t'(2'(pi)));
      eq  = (fill_r >= len) && !prev_r;
      for (int k = 0; k < MAX_PLEN; k++) begin
        if (k < int'(len) && win_r[k] != pat_char(pat_t'(2'(pi)), k)) eq = 1'b0;
      end
      if (fill_r > len) eq = eq && !is_alnum(win_r[len]);
      else              eq = eq && cmd.at_end;
      pat_hit[pi] = eq;
    end
  end

  // First pattern in priority order wins
  always_comb begin
    hit     = 1'b0;
    hit_pat = PAT_NEG_INF;
    for (int pi = NUM_PAT - 1; pi >= 0; pi--) begin
      if (pat_hit[pi]) begin
        hit     = 1'b1;
        hit_pat = pat_t'(2'(pi));
      end
    end
  end

  assign hit_len  = pat_len(hit_pat);
  assign head_rep = !instr_r && hit;

  // How many bytes leave the window this cycle
  always_comb begin
    drop = '0;
    if (cmd.head_go) drop = head_rep ? hit_len : 4'd1;
  end

  assign fill_mid = fill_r - drop;
  assign fill_nxt = fill_mid + {{(FILL_W-1){1'b0}}, cmd.append};

  // Window shift by the consumed length, then append at the new tail
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) win_nxt[i] = win_r[i];
    case (drop)
      4'd1: for (int i = 0; i + 1 < WIN_DEPTH; i++) win_nxt[i] = win_r[i + 1];
      PLEN_NAN: for (int i = 0; i + 3 < WIN_DEPTH; i++) win_nxt[i] = win_r[i + 3];
      PLEN_POS: for (int i = 0; i + 8 < WIN_DEPTH; i++) win_nxt[i] = win_r[i + 8];
      PLEN_NEG: for (int i = 0; i + 9 < WIN_DEPTH; i++) win_nxt[i] = win_r[i + 9];
      default: ;
    endcase
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (cmd.append && fill_mid == FILL_W'(i)) win_nxt[i] = in_byte;
    end
  end

  // Output beat selection; last byte of a flushed text carries out_last
  assign emit     = cmd.head_go || cmd.rep_go;
  assign text_end = cmd.at_end &&
                    ((cmd.head_go && !head_rep && fill_r == 4'd1) ||
                     (cmd.rep_go && rep_final && fill_r == '0));

  always_comb begin
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      olast_nxt  = text_end;
      if (cmd.rep_go)    obyte_nxt = rep_char(rep_pat_r, rep_cnt_r);
      else if (head_rep) obyte_nxt = rep_char(hit_pat, '0);
      else               obyte_nxt = head;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  // String, escape and border flags
  always_comb begin
    instr_nxt   = instr_r;
    esc_nxt     = esc_r;
    prev_nxt    = prev_r;
    rep_pat_nxt = rep_pat_r;
    rep_cnt_nxt = rep_cnt_r;
    if (cmd.head_go) begin
      if (instr_r) begin
        if (esc_r)                  esc_nxt   = 1'b0;
        else if (head == CH_BSLASH) esc_nxt   = 1'b1;
        else if (head == CH_QUOTE)  instr_nxt = 1'b0;
        prev_nxt = is_alnum(head);
      end else if (head_rep) begin
        prev_nxt    = is_alnum(pat_char(hit_pat, int'(hit_len) - 1));
        rep_pat_nxt = hit_pat;
        rep_cnt_nxt = 5'd1;
      end else begin
        if (head == CH_QUOTE) instr_nxt = 1'b1;
        prev_nxt = is_alnum(head);
      end
    end
    if (cmd.rep_go) rep_cnt_nxt = rep_cnt_r + 5'd1;
    // next text starts fresh
    if (text_end) begin
      instr_nxt = 1'b0;
      esc_nxt   = 1'b0;
      prev_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      instr_r  <= 1'b0;
      esc_r    <= 1'b0;
      prev_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      instr_r  <= instr_nxt;
      esc_r    <= esc_nxt;
      prev_r   <= prev_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_DEPTH; i++) win_r[i] <= win_nxt[i];
    rep_pat_r <= rep_pat_nxt;
    rep_cnt_r <= rep_cnt_nxt;
    obyte_r   <= obyte_nxt;
    olast_r   <= olast_nxt;
  end

  assign sts.full      = (fill_r == FILL_W'(WIN_DEPTH));
  assign sts.fill_zero = (fill_r == '0);
  assign sts.fill_one  = (fill_r == 4'd1);
  assign sts.head_rep  = head_rep;
  assign sts.rep_final = rep_final;
  assign sts.emit_ok   = emit_ok;

  assign out_valid = ovalid_r;
  assign out_byte  = obyte_r;
  assign out_last  = olast_r;

endmodule

// ===== rtl/core/jnlr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jnlr_ctrl: sequencing controller for the literal rewriter
// Decides when the window head is resolved, steps replacement text out
// and runs the end-of-text flush; owns the input ready.
// ----------------------------------------------------------------------------
module jnlr_ctrl import jnlr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    S_RUN,
    S_REP,
    S_FLUSH,
    S_FLUSH_REP
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  always_comb begin
    cmd         = '0;
    in_ready    = 1'b0;
    state_nxt   = state_r;
    cmd.at_end  = (state_r == S_FLUSH) || (state_r == S_FLUSH_REP);
    unique case (state_r)
      // Streaming: resolve the head once the window is full, take input
      // in the same cycle when the head leaves as a single byte
      S_RUN: begin
        cmd.head_go = sts.full && sts.emit_ok;
        in_ready    = !sts.full || (sts.emit_ok && !sts.head_rep);
        if (cmd.head_go && sts.head_rep)  state_nxt = S_REP;
        else if (in_valid && in_ready && in_last) state_nxt = S_FLUSH;
      end
      S_REP: begin
        cmd.rep_go = sts.emit_ok;
        if (cmd.rep_go && sts.rep_final) state_nxt = S_RUN;
      end
      // Drain the window with end of text as a border
      S_FLUSH: begin
        cmd.head_go = sts.emit_ok && !sts.fill_zero;
        if (sts.fill_zero)                     state_nxt = S_RUN;
        else if (cmd.head_go && sts.head_rep)  state_nxt = S_FLUSH_REP;
        else if (cmd.head_go && sts.fill_one)  state_nxt = S_RUN;
      end
      S_FLUSH_REP: begin
        cmd.rep_go = sts.emit_ok;
        if (cmd.rep_go && sts.rep_final) state_nxt = sts.fill_zero ? S_RUN : S_FLUSH;
      end
      default: state_nxt = S_RUN;
    endcase
    accept     = in_valid && in_ready;
    cmd.append = accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_RUN;
    else        state_r <= state_nxt;
  end

endmodule

// ===== rtl/core/json_nonfinite_literal_rewriter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_nonfinite_literal_rewriter: JSON non-finite literal rewriter
// Input channel in_if carries one JSON text byte per beat with in_last on
// the final byte. Output channel out_if carries the rewritten text, one byte
// per beat, out_last on its final byte. Outside strings the words -Infinity,
// Infinity, NaN and nan become -1.7976931348623157e+308,
// 1.7976931348623157e+308, null and null when bordered by non-alphanumerics.
//
// Bytes pass through a ten-byte lookahead window: a byte is resolved once
// nine more bytes have arrived behind it, and its output beat is then
// registered in the output register; in_last drains the window instead.
// Steady state is one byte per cycle while the receiver takes each beat
// and no word is replaced. A replaced word holds input while its
// replacement bytes (24, 23 or 4) step out of the single output register.
// The flush emits the window's rest, at most 25 output bytes, input held.
// When the receiver stalls, the output register holds its beat and input
// stalls as soon as the window is full. Reset empties the window, clears the
// string and border state, and drops any pending output beat.
// ----------------------------------------------------------------------------
module json_nonfinite_literal_rewriter import jnlr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  jnlr_in_if.sink     in_if,
  jnlr_out_if.source  out_if
);

  cmd_t cmd;
  sts_t sts;

  jnlr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_last  (in_if.in_last),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jnlr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (in_if.in_byte),
    .out_valid (out_if.valid),
    .out_byte  (out_if.out_byte),
    .out_last  (out_if.out_last),
    .out_ready (out_if.ready)
  );

endmodule
